// ----- rtl/fbfl_pkg.sv -----
// Package for the fixed-block free-list allocator: field widths, command and
// status codes, register indexes, reset values and controller/datapath structs.
// No dependencies.
package fbfl_pkg;

    localparam int DEFAULT_MAX_BLOCKS = 1024;

    localparam int CMD_W    = 2;
    localparam int IDX_W    = 10;
    localparam int OFF_W    = 26;
    localparam int CNT_W    = 11;
    localparam int STATUS_W = 2;
    localparam int BCNT_W   = 11;
    localparam int BSIZE_W  = 17;
    localparam int CFG_W    = 17;
    localparam int CFG_ADDR_W = 1;
    localparam int PROD_W   = IDX_W + BSIZE_W;

    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 56;
    localparam int M_FIELDS_W = STATUS_W + IDX_W + OFF_W + CNT_W;

    typedef logic [CMD_W-1:0]    cmd_t;
    typedef logic [STATUS_W-1:0] status_t;

    localparam cmd_t CMD_ALLOC      = 2'd0;
    localparam cmd_t CMD_FREE       = 2'd1;
    localparam cmd_t CMD_RESET_POOL = 2'd2;

    localparam status_t STATUS_OK     = 2'd0;
    localparam status_t STATUS_EMPTY  = 2'd1;
    localparam status_t STATUS_REJECT = 2'd2;

    localparam logic [CFG_ADDR_W-1:0] REG_BLOCK_COUNT = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_BLOCK_SIZE  = 1'd1;

    localparam logic [BCNT_W-1:0]  BLOCK_COUNT_RESET = 11'd1024;
    localparam logic [BSIZE_W-1:0] BLOCK_SIZE_RESET  = 17'd64;
    localparam logic [BSIZE_W-1:0] MIN_BLOCK_SIZE    = 17'd8;
    localparam logic [BSIZE_W-1:0] MAX_BLOCK_SIZE    = 17'd65536;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_READ,
        ST_DONE
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic latch_in;
        logic exec;
        logic capture;
        logic load_out;
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic need_read;
        logic out_free;
    } dp_stat_t;

endpackage

// ----- rtl/fbfl_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module fbfl_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/fbfl_ctrl.sv -----
// Controller state machine for the free-list allocator.
// Depends on fbfl_pkg; drives the datapath through dp_cmd_t.
module fbfl_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  fbfl_pkg::dp_stat_t stat,
    output fbfl_pkg::dp_cmd_t  cmd
);
    import fbfl_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                state_next = stat.need_read ? ST_READ : ST_DONE;
            end
            ST_READ: begin
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (stat.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        cmd           = '0;
        s_axis_tready = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_axis_tready = 1'b1;
                cmd.latch_in  = s_axis_tvalid;
            end
            ST_EXEC: begin
                cmd.exec = 1'b1;
            end
            ST_READ: begin
                cmd.capture = 1'b1;
            end
            ST_DONE: begin
                cmd.load_out = stat.out_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

    // A fetched word must follow every pop
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EXEC && stat.need_read) |=> (state_reg == ST_READ))
        else $error("pop not followed by read stage");

endmodule

// ----- rtl/fbfl_dp.sv -----
// Datapath of the free-list allocator: config registers, stack pointer, in-use
// counter, pristine mark, stack RAM, offset multiplier and output register.
// Depends on fbfl_pkg and fbfl_ram.
module fbfl_dp #(
    parameter int MAX_BLOCKS = fbfl_pkg::DEFAULT_MAX_BLOCKS
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_we,
    input  logic [fbfl_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  logic [fbfl_pkg::CFG_W-1:0]           cfg_wdata,
    input  fbfl_pkg::cmd_t                       in_cmd,
    input  logic [fbfl_pkg::IDX_W-1:0]           in_block_index,
    input  logic                                 in_no_block,
    input  fbfl_pkg::dp_cmd_t                    cmd,
    output fbfl_pkg::dp_stat_t                   stat,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output fbfl_pkg::status_t                    m_status,
    output logic [fbfl_pkg::IDX_W-1:0]           m_granted_index,
    output logic [fbfl_pkg::OFF_W-1:0]           m_granted_offset,
    output logic [fbfl_pkg::CNT_W-1:0]           m_in_use_count
);
    import fbfl_pkg::*;

    localparam int AW = $clog2(MAX_BLOCKS);
    localparam int PW = $clog2(MAX_BLOCKS + 1);

    // Stack depth after hardware reset, from the register default rather than
    // the register itself
    localparam logic [PW-1:0] RESET_DEPTH =
        (32'(BLOCK_COUNT_RESET) > 32'(MAX_BLOCKS)) ? PW'(MAX_BLOCKS)
                                                   : PW'(BLOCK_COUNT_RESET);

    // Configuration
    logic [BCNT_W-1:0]  block_count_reg;
    logic [BSIZE_W-1:0] block_size_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            block_count_reg <= BLOCK_COUNT_RESET;
            block_size_reg  <= BLOCK_SIZE_RESET;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_BLOCK_COUNT: block_count_reg <= cfg_wdata[BCNT_W-1:0];
                REG_BLOCK_SIZE:  block_size_reg  <= cfg_wdata[BSIZE_W-1:0];
                default: ;
            endcase
        end
    end

    logic [PW-1:0]      eff_count;
    logic [BSIZE_W-1:0] eff_size;

    assign eff_count = (32'(block_count_reg) > 32'(MAX_BLOCKS)) ? PW'(MAX_BLOCKS)
                                                               : PW'(block_count_reg);

    always_comb begin
        eff_size = block_size_reg;
        if (block_size_reg < MIN_BLOCK_SIZE) begin
            eff_size = MIN_BLOCK_SIZE;
        end else if (block_size_reg > MAX_BLOCK_SIZE) begin
            eff_size = MAX_BLOCK_SIZE;
        end
    end

    // Latched input word
    cmd_t             cmd_reg;
    logic [IDX_W-1:0] idx_in_reg;
    logic             none_reg;

    always_ff @(posedge aclk) begin
        if (cmd.latch_in) begin
            cmd_reg    <= in_cmd;
            idx_in_reg <= in_block_index;
            none_reg   <= in_no_block;
        end
    end

    // Stack state. Positions below mark_reg still hold their rebuild value,
    // i.e. their own position, and are never read from the RAM.
    logic [PW-1:0] depth_reg, depth_next;
    logic [PW-1:0] alloc_reg, alloc_next;
    logic [PW-1:0] mark_reg,  mark_next;
    logic [PW-1:0] pop_pos;
    logic          pop_pristine;
    logic          need_read;
    logic          push;
    status_t       status_next;

    assign pop_pos      = depth_reg - PW'(1);
    assign pop_pristine = pop_pos < mark_reg;

    always_comb begin
        depth_next  = depth_reg;
        alloc_next  = alloc_reg;
        mark_next   = mark_reg;
        need_read   = 1'b0;
        push        = 1'b0;
        status_next = STATUS_OK;
        unique case (cmd_reg)
            CMD_ALLOC: begin
                if (depth_reg == '0) begin
                    status_next = STATUS_EMPTY;
                end else begin
                    need_read  = 1'b1;
                    depth_next = pop_pos;
                    alloc_next = alloc_reg + PW'(1);
                    if (pop_pristine) begin
                        mark_next = pop_pos;
                    end
                end
            end
            CMD_FREE: begin
                if (!none_reg) begin
                    if (alloc_reg == '0) begin
                        status_next = STATUS_REJECT;
                    end else begin
                        alloc_next = alloc_reg - PW'(1);
                        // drop the push when the stack is already full
                        if (32'(depth_reg) < 32'(MAX_BLOCKS)) begin
                            push       = 1'b1;
                            depth_next = depth_reg + PW'(1);
                        end
                    end
                end
            end
            CMD_RESET_POOL: begin
                depth_next = eff_count;
                mark_next  = eff_count;
                alloc_next = '0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            depth_reg <= RESET_DEPTH;
            mark_reg  <= RESET_DEPTH;
            alloc_reg <= '0;
        end else if (cmd.exec) begin
            depth_reg <= depth_next;
            mark_reg  <= mark_next;
            alloc_reg <= alloc_next;
        end
    end

    // Stack memory
    logic [IDX_W-1:0] ram_rdata;

    fbfl_ram #(
        .WIDTH (IDX_W),
        .DEPTH (MAX_BLOCKS)
    ) u_stack (
        .aclk  (aclk),
        .we    (cmd.exec && push),
        .waddr (AW'(depth_reg)),
        .wdata (idx_in_reg),
        .re    (cmd.exec && need_read),
        .raddr (AW'(pop_pos)),
        .rdata (ram_rdata)
    );

    // Result staging
    status_t          res_status_reg;
    logic [IDX_W-1:0] res_index_reg;
    logic [OFF_W-1:0] res_offset_reg;
    logic [CNT_W-1:0] res_count_reg;
    logic [IDX_W-1:0] pos_idx_reg;
    logic             pristine_reg;
    logic [IDX_W-1:0] popped_index;
    logic [PROD_W-1:0] product;

    assign popped_index = pristine_reg ? pos_idx_reg : ram_rdata;
    assign product      = PROD_W'(popped_index) * PROD_W'(eff_size);

    always_ff @(posedge aclk) begin
        if (cmd.exec) begin
            res_status_reg <= status_next;
            res_count_reg  <= CNT_W'(alloc_next);
            res_index_reg  <= '0;
            res_offset_reg <= '0;
            pos_idx_reg    <= IDX_W'(pop_pos);
            pristine_reg   <= pop_pristine;
        end else if (cmd.capture) begin
            res_index_reg  <= popped_index;
            res_offset_reg <= product[OFF_W-1:0];
        end
    end

    // Output register
    logic             out_valid_reg;
    status_t          out_status_reg;
    logic [IDX_W-1:0] out_index_reg;
    logic [OFF_W-1:0] out_offset_reg;
    logic [CNT_W-1:0] out_count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            out_status_reg <= res_status_reg;
            out_index_reg  <= res_index_reg;
            out_offset_reg <= res_offset_reg;
            out_count_reg  <= res_count_reg;
        end
    end

    // Status to the controller: need_read above out_free
    assign stat             = {need_read, (!out_valid_reg || m_ready)};
    assign m_valid          = out_valid_reg;
    assign m_status         = out_status_reg;
    assign m_granted_index  = out_index_reg;
    assign m_granted_offset = out_offset_reg;
    assign m_in_use_count   = out_count_reg;

    // Pushes only land at or above the lowest point reached since rebuild
    assert property (@(posedge aclk) disable iff (!aresetn)
        mark_reg <= depth_reg)
        else $error("pristine mark above stack depth");

    assert property (@(posedge aclk) disable iff (!aresetn)
        32'(depth_reg) <= 32'(MAX_BLOCKS))
        else $error("stack depth beyond pool size");

    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> (!out_valid_reg || m_ready))
        else $error("pending output word overwritten");

    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |=> out_valid_reg)
        else $error("loaded word not presented");

endmodule

// ----- rtl/fixed_block_free_list_allocator_top.sv -----
// Top level of the fixed-block free-list allocator.
// Depends on fbfl_pkg, fbfl_ctrl and fbfl_dp (which holds fbfl_ram).
//
// Usage:
//   Input stream (s_axis_*): one command word per handshake. tdata carries
//   cmd (allocate, free, reset pool) and block_index; tuser carries no_block.
//   Output stream (m_axis_*): exactly one result word per command: status,
//   granted index, byte offset (index times block size) and blocks in use.
//   Config port: cfg_we with cfg_addr 0 (block_count) or 1 (block_size);
//   block_count applies at the next reset-pool command, block_size at once.
// Timing:
//   One command is in flight at a time. The command is latched, then passes
//   the EXEC state, for a successful allocate the READ state (registered
//   stack RAM read, offset multiply in the same stage), and the DONE state,
//   which loads the result word into the output register. A new command is
//   taken while the previous result still sits in the output register.
// Reset:
//   aresetn (synchronous, active low) restores the register defaults and an
//   empty in-use count with the stack full, highest index handed out first.
//   No clearing pass is needed; the stack is ready the cycle after reset.
// Back-pressure:
//   While m_axis_tready is low the result word is held and, once the next
//   result is ready, the block stops taking commands.
module fixed_block_free_list_allocator_top #(
    parameter int MAX_BLOCKS = fbfl_pkg::DEFAULT_MAX_BLOCKS
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_we,
    input  logic [fbfl_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  logic [fbfl_pkg::CFG_W-1:0]           cfg_wdata,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // [1:0] cmd, [11:2] block_index, [15:12] zero
    input  logic [fbfl_pkg::S_TDATA_W-1:0]       s_axis_tdata,
    // [0] no_block
    input  logic                                 s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // [1:0] status, [11:2] granted_index, [37:12] granted_offset,
    // [48:38] in_use_count, [55:49] zero
    output logic [fbfl_pkg::M_TDATA_W-1:0]       m_axis_tdata
);
    import fbfl_pkg::*;

    dp_cmd_t          cmd;
    dp_stat_t         stat;
    status_t          out_status;
    logic [IDX_W-1:0] out_index;
    logic [OFF_W-1:0] out_offset;
    logic [CNT_W-1:0] out_count;

    fbfl_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .stat          (stat),
        .cmd           (cmd)
    );

    fbfl_dp #(
        .MAX_BLOCKS (MAX_BLOCKS)
    ) u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_we           (cfg_we),
        .cfg_addr         (cfg_addr),
        .cfg_wdata        (cfg_wdata),
        .in_cmd           (s_axis_tdata[CMD_W-1:0]),
        .in_block_index   (s_axis_tdata[CMD_W+IDX_W-1:CMD_W]),
        .in_no_block      (s_axis_tuser),
        .cmd              (cmd),
        .stat             (stat),
        .m_valid          (m_axis_tvalid),
        .m_ready          (m_axis_tready),
        .m_status         (out_status),
        .m_granted_index  (out_index),
        .m_granted_offset (out_offset),
        .m_in_use_count   (out_count)
    );

    assign m_axis_tdata = {(M_TDATA_W - M_FIELDS_W)'(0),
                           out_count, out_offset, out_index, out_status};

endmodule
